/* rtl/sba_pkg.sv */
// shared constants, types and helpers of the skyline block allocator
`default_nettype none

package sba_pkg;

  localparam int PAGE_SIZE = 128;
  localparam int AW = $clog2(PAGE_SIZE);
  localparam int HW = $clog2(PAGE_SIZE + 1);
  localparam int WW = 8;
  localparam int XW = 7;
  localparam int YW = 8;
  localparam int SW = ((WW > HW) ? WW : HW) + 1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef logic [HW-1:0] height_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BWD,
    ST_BWD_WAIT,
    ST_FWD,
    ST_FWD_WAIT,
    ST_EVAL,
    ST_WRITE
  } state_e;

  function automatic height_t hmax(input height_t a, input height_t b);
    hmax = (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

/* rtl/sba_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module sba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/skyline_block_allocator.sv */
// skyline block allocator top level: column height memory, scan and write-back
//
// usage: a request is taken at a rising edge with start_i high and busy_o low.
// mode_i selects allocate or clear page; block_width_i and block_height_i give
// the block in cells. every request yields one result: done_o is high for one
// cycle with granted_o, pos_x_o and pos_y_o; the receiver cannot stall it.
// a clear request, or an allocate whose width is zero or wider than the page,
// answers in the cycle after it is taken. an allocate runs a backward pass
// over the column memory building per-block suffix maxima, a forward pass
// that combines them with running prefix maxima into each window's height,
// an evaluation step and, when granted, a write of each block column.
// the two passes are set by the single read port of the column memory.
// busy_o stays high until the result is shown; a new request can be taken
// in the cycle done_o is high. reset empties the page at once through one
// valid bit per column; a clear request does the same at once.
`default_nettype none

module skyline_block_allocator (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic                    mode_i,
  input  wire logic [sba_pkg::WW-1:0]  block_width_i,
  input  wire logic [sba_pkg::WW-1:0]  block_height_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic                         granted_o,
  output logic      [sba_pkg::XW-1:0]  pos_x_o,
  output logic      [sba_pkg::YW-1:0]  pos_y_o
);

  sba_pkg::state_e state_q, state_d;

  logic [sba_pkg::AW-1:0] a_q, a_d;
  logic [sba_pkg::AW-1:0] px_q, px_d;
  logic [sba_pkg::AW-1:0] wend_q, wend_d;
  logic [sba_pkg::WW-1:0] wm1_q, wm1_d;
  logic [sba_pkg::WW-1:0] bh_q, bh_d;
  logic [sba_pkg::WW-1:0] k_q, k_d;
  sba_pkg::height_t       suf_q, suf_d;
  sba_pkg::height_t       pre_q, pre_d;
  sba_pkg::height_t       best_q, best_d;

  logic                   s1_vld_q, s1_win_q, s1_hv_q;
  logic [sba_pkg::AW-1:0] s1_addr_q, s1_ws_q;
  logic [sba_pkg::PAGE_SIZE-1:0] hvalid_q;

  logic                   done_q, done_d, granted_q, granted_d;
  logic [sba_pkg::XW-1:0] posx_q, posx_d;
  logic [sba_pkg::YW-1:0] posy_q, posy_d;

  logic                   accept, clr, w_bad, issue, bwd_proc, fwd_proc, s_we, h_we;
  logic                   found, fits, win;
  logic [sba_pkg::WW-1:0] ws_full;
  logic [sba_pkg::SW-1:0] sum;
  sba_pkg::height_t       h_rdata, s_rdata, hcur, wmax, h_wdata;

  assign accept  = start_i && (state_q == sba_pkg::ST_IDLE);
  assign w_bad   = (block_width_i == '0) ||
                   (sba_pkg::SW'(block_width_i) > sba_pkg::SW'(sba_pkg::PAGE_SIZE));
  assign sum     = sba_pkg::SW'(best_q) + sba_pkg::SW'(bh_q);
  assign found   = best_q < sba_pkg::HW'(sba_pkg::PAGE_SIZE);
  assign fits    = sum <= sba_pkg::SW'(sba_pkg::PAGE_SIZE);
  assign h_wdata = sum[sba_pkg::HW-1:0];
  assign hcur    = s1_hv_q ? h_rdata : '0;
  assign win     = sba_pkg::WW'(a_q) >= wm1_q;
  assign ws_full = sba_pkg::WW'(a_q) - wm1_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sba_pkg::ST_IDLE: begin
        if (accept && (mode_i == sba_pkg::MODE_ALLOC) && !w_bad) begin
          state_d = sba_pkg::ST_BWD;
        end
      end
      sba_pkg::ST_BWD: begin
        if (a_q == '0) state_d = sba_pkg::ST_BWD_WAIT;
      end
      sba_pkg::ST_BWD_WAIT: state_d = sba_pkg::ST_FWD;
      sba_pkg::ST_FWD: begin
        if (a_q == sba_pkg::AW'(sba_pkg::PAGE_SIZE - 1)) state_d = sba_pkg::ST_FWD_WAIT;
      end
      sba_pkg::ST_FWD_WAIT: state_d = sba_pkg::ST_EVAL;
      sba_pkg::ST_EVAL: begin
        state_d = (found && fits) ? sba_pkg::ST_WRITE : sba_pkg::ST_IDLE;
      end
      sba_pkg::ST_WRITE: begin
        if (a_q == wend_q) state_d = sba_pkg::ST_IDLE;
      end
      default: state_d = sba_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    issue    = (state_q == sba_pkg::ST_BWD) || (state_q == sba_pkg::ST_FWD);
    bwd_proc = s1_vld_q &&
               ((state_q == sba_pkg::ST_BWD) || (state_q == sba_pkg::ST_BWD_WAIT));
    fwd_proc = s1_vld_q &&
               ((state_q == sba_pkg::ST_FWD) || (state_q == sba_pkg::ST_FWD_WAIT));
    s_we     = bwd_proc;
    h_we     = (state_q == sba_pkg::ST_WRITE);
    clr      = accept && (mode_i == sba_pkg::MODE_CLEAR);
    busy_o   = (state_q != sba_pkg::ST_IDLE);
  end

  // datapath and result
  always_comb begin
    a_d       = a_q;
    px_d      = px_q;
    wend_d    = wend_q;
    wm1_d     = wm1_q;
    bh_d      = bh_q;
    k_d       = k_q;
    suf_d     = suf_q;
    pre_d     = pre_q;
    best_d    = best_q;
    wmax      = '0;
    done_d    = 1'b0;
    granted_d = granted_q;
    posx_d    = posx_q;
    posy_d    = posy_q;

    case (state_q)
      sba_pkg::ST_IDLE: begin
        if (accept) begin
          a_d    = sba_pkg::AW'(sba_pkg::PAGE_SIZE - 1);
          wm1_d  = block_width_i - 1'b1;
          k_d    = block_width_i - 1'b1;
          bh_d   = block_height_i;
          best_d = sba_pkg::HW'(sba_pkg::PAGE_SIZE);
          px_d   = '0;
          if ((mode_i == sba_pkg::MODE_CLEAR) || w_bad) begin
            done_d    = 1'b1;
            granted_d = (mode_i == sba_pkg::MODE_CLEAR);
            posx_d    = '0;
            posy_d    = '0;
          end
        end
      end
      sba_pkg::ST_BWD:      a_d = a_q - 1'b1;
      sba_pkg::ST_BWD_WAIT: begin
        a_d   = '0;
        pre_d = '0;
      end
      sba_pkg::ST_FWD:      a_d = a_q + 1'b1;
      sba_pkg::ST_EVAL: begin
        a_d    = px_q;
        wend_d = px_q + wm1_q[sba_pkg::AW-1:0];
        if (!found) begin
          done_d    = 1'b1;
          granted_d = 1'b0;
          posx_d    = '0;
          posy_d    = '0;
        end else if (!fits) begin
          done_d    = 1'b1;
          granted_d = 1'b0;
          posx_d    = sba_pkg::XW'(px_q);
          posy_d    = sba_pkg::YW'(best_q);
        end
      end
      sba_pkg::ST_WRITE: begin
        a_d = a_q + 1'b1;
        if (a_q == wend_q) begin
          done_d    = 1'b1;
          granted_d = 1'b1;
          posx_d    = sba_pkg::XW'(px_q);
          posy_d    = sba_pkg::YW'(best_q);
        end
      end
      default: ;
    endcase

    // backward pass: suffix maximum within each block of width columns
    if (bwd_proc) begin
      suf_d = (k_q == wm1_q) ? hcur : sba_pkg::hmax(suf_q, hcur);
      // keep the block phase of column zero for the forward pass
      if (state_q != sba_pkg::ST_BWD_WAIT) begin
        k_d = (k_q == '0) ? wm1_q : k_q - 1'b1;
      end
    end

    // forward pass: prefix maximum joined with the suffix at the window start
    if (fwd_proc) begin
      pre_d = (k_q == '0) ? hcur : sba_pkg::hmax(pre_q, hcur);
      k_d   = (k_q == wm1_q) ? '0 : k_q + 1'b1;
      wmax  = sba_pkg::hmax(s_rdata, pre_d);
      if (s1_win_q && (wmax < best_q)) begin
        best_d = wmax;
        px_d   = s1_ws_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sba_pkg::ST_IDLE;
      s1_vld_q <= 1'b0;
      hvalid_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      s1_vld_q <= issue;
      done_q   <= done_d;
      if (clr) begin
        hvalid_q <= '0;
      end else if (h_we) begin
        hvalid_q[a_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    px_q      <= px_d;
    wend_q    <= wend_d;
    wm1_q     <= wm1_d;
    bh_q      <= bh_d;
    k_q       <= k_d;
    suf_q     <= suf_d;
    pre_q     <= pre_d;
    best_q    <= best_d;
    granted_q <= granted_d;
    posx_q    <= posx_d;
    posy_q    <= posy_d;
    s1_addr_q <= a_q;
    s1_win_q  <= win;
    s1_ws_q   <= ws_full[sba_pkg::AW-1:0];
    s1_hv_q   <= hvalid_q[a_q];
  end

  sba_ram #(
    .WIDTH(sba_pkg::HW),
    .DEPTH(sba_pkg::PAGE_SIZE)
  ) u_height_ram (
    .clk_i  (clk_i),
    .we_i   (h_we),
    .waddr_i(a_q),
    .wdata_i(h_wdata),
    .raddr_i(a_q),
    .rdata_o(h_rdata)
  );

  sba_ram #(
    .WIDTH(sba_pkg::HW),
    .DEPTH(sba_pkg::PAGE_SIZE)
  ) u_suffix_ram (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s1_addr_q),
    .wdata_i(suf_d),
    .raddr_i(ws_full[sba_pkg::AW-1:0]),
    .rdata_o(s_rdata)
  );

  assign done_o    = done_q;
  assign granted_o = granted_q;
  assign pos_x_o   = posx_q;
  assign pos_y_o   = posy_q;

`ifndef NO_ASSERTIONS
  a_busy_ends_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result");

  a_read_pipe_from_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> $past(state_q == sba_pkg::ST_BWD || state_q == sba_pkg::ST_FWD))
    else $error("read pipe valid outside a scan pass");

  a_best_in_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sba_pkg::ST_EVAL |-> best_q <= sba_pkg::HW'(sba_pkg::PAGE_SIZE))
    else $error("best height above page");

  a_grant_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && granted_o && $past(state_q == sba_pkg::ST_WRITE) |->
      (sba_pkg::SW'(pos_y_o) + sba_pkg::SW'(bh_q)) <= sba_pkg::SW'(sba_pkg::PAGE_SIZE))
    else $error("granted block exceeds page top");
`endif

endmodule

`default_nettype wire
